>>> design/dtm_pkg.sv
// ----------------------------------------------------------------------------
// dtm_pkg: shared types and constants of the dual trimmed-mean OCV selector
// Sizes of the accumulators, item layouts, status codes and register indexes.
// ----------------------------------------------------------------------------
package dtm_pkg;

  localparam int unsigned MaxGroupSamples = 16;
  localparam int unsigned SampleW = 16;
  localparam int unsigned TallyW = $clog2(MaxGroupSamples + 1);
  localparam int unsigned TotalW = SampleW + TallyW;
  localparam int unsigned DivCntW = $clog2(TotalW);
  localparam int unsigned MinTally = 3;

  localparam int unsigned CfgIndexW = 2;
  localparam logic [CfgIndexW-1:0] CfgMeanDiff = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgSpread = 2'd1;

  localparam logic [SampleW-1:0] MeanDiffReset = 16'h0029;
  localparam logic [SampleW-1:0] SpreadReset = 16'h0200;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_LARGE_FEW   = 2'd1,
    STATUS_SMALL_FEW   = 2'd2,
    STATUS_OVERFLOW    = 2'd3
  } status_e;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               group;
    logic               end_of_set;
  } in_item_t;

  typedef struct packed {
    logic [SampleW-1:0] voltage_estimate;
    logic               used_small;
    status_e            status;
  } out_item_t;

  typedef struct packed {
    logic [SampleW-1:0] minimum;
    logic [SampleW-1:0] maximum;
    logic [TotalW-1:0]  total;
    logic [TallyW-1:0]  tally;
  } group_acc_t;

  // Everything the back end needs to finish one set.
  typedef struct packed {
    group_acc_t large_grp;
    group_acc_t small_grp;
    logic       overflow;
  } job_t;

endpackage

>>> design/dtm_front.sv
// ----------------------------------------------------------------------------
// dtm_front: per-sample accumulation
// Keeps min, max, sum and count of both groups and hands a finished set to the
// job queue on the end-of-set sample, then clears for the next set.
// ----------------------------------------------------------------------------
module dtm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  dtm_pkg::in_item_t item_i,
  output logic              job_push_o,
  output dtm_pkg::job_t     job_o
);

  localparam dtm_pkg::group_acc_t AccReset = '{
    minimum: '1, maximum: '0, total: '0, tally: '0
  };

  dtm_pkg::group_acc_t large_q, large_d, small_q, small_d;
  logic                overflow_q, overflow_d;
  dtm_pkg::group_acc_t sel_acc, upd_acc;
  logic                sel_full;

  always_comb begin
    sel_acc  = item_i.group ? small_q : large_q;
    sel_full = (sel_acc.tally >= dtm_pkg::TallyW'(dtm_pkg::MaxGroupSamples));
    upd_acc  = sel_acc;
    if (!sel_full) begin
      if (item_i.sample < sel_acc.minimum) upd_acc.minimum = item_i.sample;
      if (item_i.sample > sel_acc.maximum) upd_acc.maximum = item_i.sample;
      upd_acc.total = sel_acc.total + dtm_pkg::TotalW'(item_i.sample);
      upd_acc.tally = sel_acc.tally + dtm_pkg::TallyW'(1);
    end
  end

  always_comb begin
    large_d    = large_q;
    small_d    = small_q;
    overflow_d = overflow_q;
    if (accept_i) begin
      if (item_i.group) begin
        small_d = upd_acc;
      end else begin
        large_d = upd_acc;
      end
      overflow_d = overflow_q | sel_full;
    end
  end

  assign job_push_o = accept_i & item_i.end_of_set;
  assign job_o      = '{large_grp: large_d, small_grp: small_d, overflow: overflow_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      large_q    <= AccReset;
      small_q    <= AccReset;
      overflow_q <= 1'b0;
    end else if (job_push_o) begin
      large_q    <= AccReset;
      small_q    <= AccReset;
      overflow_q <= 1'b0;
    end else begin
      large_q    <= large_d;
      small_q    <= small_d;
      overflow_q <= overflow_d;
    end
  end

endmodule

>>> design/dtm_job_fifo.sv
// ----------------------------------------------------------------------------
// dtm_job_fifo: two-entry queue of finished sets
// Decouples sample accumulation from the division and selection back end.
// ----------------------------------------------------------------------------
module dtm_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dtm_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output dtm_pkg::job_t job_o
);

  dtm_pkg::job_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

>>> design/dtm_back.sv
// ----------------------------------------------------------------------------
// dtm_back: trimmed means, selection and result queue
// Checks the counts, runs the large and any small trimmed-mean division (none
// for an error set) through one restoring divider that retires one quotient
// bit per cycle, selects the estimate and holds results in a two-entry queue.
// ----------------------------------------------------------------------------
module dtm_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_empty_i,
  input  dtm_pkg::job_t               job_i,
  output logic                        job_pop_o,
  input  logic [dtm_pkg::SampleW-1:0] mean_diff_i,
  input  logic [dtm_pkg::SampleW-1:0] spread_limit_i,
  input  logic                        pop_i,
  output logic                        empty_o,
  output dtm_pkg::out_item_t          result_o
);

  localparam int unsigned RemW = dtm_pkg::TallyW + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LDIV = 4'b0010,
    S_SDIV = 4'b0100,
    S_OUT  = 4'b1000
  } back_state_e;

  back_state_e                  state_q, state_d;
  dtm_pkg::job_t                job_q;
  dtm_pkg::status_e             status_q, status_d;
  logic [dtm_pkg::SampleW-1:0]  lm_q, sm_q;
  logic [dtm_pkg::TotalW-1:0]   quo_q, quo_d;
  logic [RemW-1:0]              rem_q, rem_d;
  logic [dtm_pkg::TallyW-1:0]   div_q, div_d;
  logic [dtm_pkg::DivCntW-1:0]  cnt_q, cnt_d;

  logic [RemW-1:0]              shifted, rem_step;
  logic                         ge;
  logic [dtm_pkg::TotalW-1:0]   quo_step;

  logic [dtm_pkg::SampleW-1:0]  diff, spread;
  logic                         pick_large;
  dtm_pkg::out_item_t           res_new;

  // Result queue.
  dtm_pkg::out_item_t           res_mem_q [2];
  logic                         res_wr_q, res_rd_q;
  logic [1:0]                   res_cnt_q;
  logic                         res_full, res_push, res_pop;

  // One restoring division step.
  always_comb begin
    shifted  = {rem_q[dtm_pkg::TallyW-1:0], quo_q[dtm_pkg::TotalW-1]};
    ge       = (shifted >= {1'b0, div_q});
    rem_step = ge ? (shifted - {1'b0, div_q}) : shifted;
    quo_step = {quo_q[dtm_pkg::TotalW-2:0], ge};
  end

  always_comb begin
    status_d = dtm_pkg::STATUS_OK;
    if (job_i.overflow) begin
      status_d = dtm_pkg::STATUS_OVERFLOW;
    end else if (job_i.large_grp.tally < dtm_pkg::TallyW'(dtm_pkg::MinTally)) begin
      status_d = dtm_pkg::STATUS_LARGE_FEW;
    end else if (job_i.small_grp.tally != '0 &&
                 job_i.small_grp.tally < dtm_pkg::TallyW'(dtm_pkg::MinTally)) begin
      status_d = dtm_pkg::STATUS_SMALL_FEW;
    end
  end

  // Selection between the two means.
  always_comb begin
    diff       = (lm_q > sm_q) ? (lm_q - sm_q) : (sm_q - lm_q);
    spread     = job_q.large_grp.maximum - job_q.large_grp.minimum;
    pick_large = (sm_q == '0) || ((diff > mean_diff_i) && (spread < spread_limit_i));
    res_new.status = status_q;
    if (status_q != dtm_pkg::STATUS_OK) begin
      res_new.voltage_estimate = '0;
      res_new.used_small       = 1'b0;
    end else begin
      res_new.voltage_estimate = pick_large ? lm_q : sm_q;
      res_new.used_small       = ~pick_large;
    end
  end

  always_comb begin
    state_d   = state_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    div_d     = div_q;
    cnt_d     = cnt_q;
    job_pop_o = 1'b0;
    res_push  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          rem_d     = '0;
          cnt_d     = dtm_pkg::DivCntW'(dtm_pkg::TotalW - 1);
          quo_d     = job_i.large_grp.total
                      - dtm_pkg::TotalW'(job_i.large_grp.minimum)
                      - dtm_pkg::TotalW'(job_i.large_grp.maximum);
          div_d     = job_i.large_grp.tally - dtm_pkg::TallyW'(2);
          state_d   = (status_d == dtm_pkg::STATUS_OK) ? S_LDIV : S_OUT;
        end
      end
      S_LDIV: begin
        quo_d = quo_step;
        rem_d = rem_step;
        cnt_d = cnt_q - dtm_pkg::DivCntW'(1);
        if (cnt_q == '0) begin
          if (job_q.small_grp.tally != '0) begin
            rem_d   = '0;
            cnt_d   = dtm_pkg::DivCntW'(dtm_pkg::TotalW - 1);
            quo_d   = job_q.small_grp.total
                      - dtm_pkg::TotalW'(job_q.small_grp.minimum)
                      - dtm_pkg::TotalW'(job_q.small_grp.maximum);
            div_d   = job_q.small_grp.tally - dtm_pkg::TallyW'(2);
            state_d = S_SDIV;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_SDIV: begin
        quo_d = quo_step;
        rem_d = rem_step;
        cnt_d = cnt_q - dtm_pkg::DivCntW'(1);
        if (cnt_q == '0) state_d = S_OUT;
      end
      S_OUT: begin
        if (!res_full) begin
          res_push = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
    cnt_q <= cnt_d;
    if (job_pop_o) begin
      job_q    <= job_i;
      status_q <= status_d;
    end
    if (state_q == S_LDIV && cnt_q == '0) begin
      lm_q <= quo_step[dtm_pkg::SampleW-1:0];
      sm_q <= '0;
    end
    if (state_q == S_SDIV && cnt_q == '0) begin
      sm_q <= quo_step[dtm_pkg::SampleW-1:0];
    end
  end

  assign res_full = (res_cnt_q == 2'd2);
  assign empty_o  = (res_cnt_q == 2'd0);
  assign res_pop  = pop_i & ~empty_o;
  assign result_o = res_mem_q[res_rd_q];

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem_q[res_wr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      if (res_push) res_wr_q <= ~res_wr_q;
      if (res_pop) res_rd_q <= ~res_rd_q;
      if (res_push && !res_pop) begin
        res_cnt_q <= res_cnt_q + 2'd1;
      end else if (res_pop && !res_push) begin
        res_cnt_q <= res_cnt_q - 2'd1;
      end
    end
  end

endmodule

>>> design/dual_trimmed_mean_ocv_select_unit.sv
// ----------------------------------------------------------------------------
// dual_trimmed_mean_ocv_select_unit: dual-group trimmed-mean OCV selector
// Samples are accumulated one per cycle; the end-of-set sample starts the
// trimmed-mean divisions and selection that produce one result per set.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while the two-entry set queue has room.
// A result reaches the result ports after the one-bit-per-cycle divider, which
// serves the large and then any small group in turn, has finished its set; an
// error set skips the divider and goes straight on to the result queue.
// Reset clears the accumulators, both queues and the back-end state, and loads
// the registers with their defaults. No clearing pass is needed.
module dual_trimmed_mean_ocv_select_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  dtm_pkg::in_item_t             item_i,
  input  logic                          pop,
  output logic                          empty,
  output dtm_pkg::out_item_t            result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dtm_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [dtm_pkg::SampleW-1:0]   cfg_data_i
);

  logic [dtm_pkg::SampleW-1:0] mean_diff_q, spread_limit_q;
  logic                        accept, job_push, job_pop, job_empty;
  dtm_pkg::job_t               job_in, job_out;

  assign cfg_ready_o = 1'b1;
  assign accept      = push & ~full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_diff_q    <= dtm_pkg::MeanDiffReset;
      spread_limit_q <= dtm_pkg::SpreadReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dtm_pkg::CfgMeanDiff: mean_diff_q    <= cfg_data_i;
        dtm_pkg::CfgSpread:   spread_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dtm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  dtm_job_fifo u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .job_o   (job_out)
  );

  dtm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_empty_i    (job_empty),
    .job_i          (job_out),
    .job_pop_o      (job_pop),
    .mean_diff_i    (mean_diff_q),
    .spread_limit_i (spread_limit_q),
    .pop_i          (pop),
    .empty_o        (empty),
    .result_o       (result_o)
  );

endmodule

>>> design/dtm_checker.sv
// ----------------------------------------------------------------------------
// dtm_checker: port-level checks of the OCV selector
// Watches the result queue behavior and the contents of delivered results.
// ----------------------------------------------------------------------------
module dtm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          push,
  input logic                          full,
  input dtm_pkg::in_item_t             item_i,
  input logic                          pop,
  input logic                          empty,
  input dtm_pkg::out_item_t            result_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [dtm_pkg::CfgIndexW-1:0] cfg_index_i,
  input logic [dtm_pkg::SampleW-1:0]   cfg_data_i
);

  // No result may be pending while reset is applied.
  assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result queue not empty during reset");

  // A waiting result that is not taken stays, unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_o))
    else $error("pending result lost or changed");

  // Error results carry no estimate.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_o.status != dtm_pkg::STATUS_OK |->
      result_o.voltage_estimate == '0 && !result_o.used_small)
    else $error("error result with nonzero fields");

  // The small mean is only chosen when it is nonzero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_o.used_small |-> result_o.voltage_estimate != '0)
    else $error("small mean chosen while zero");

endmodule

bind dual_trimmed_mean_ocv_select_unit dtm_checker u_dtm_checker (.*);

>>> dv/ocv_select_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocv_select_checker: result predictor and comparator for the OCV selector
// Watches the sample, result and register channels. It keeps its own copy of
// the group accumulators and limits, predicts the estimate of each finished
// set and compares every popped result with the oldest prediction.
// ----------------------------------------------------------------------------
module ocv_select_checker
  import dtm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 full_i,
  input  in_item_t             item_i,
  input  logic                 pop_i,
  input  logic                 empty_i,
  input  out_item_t            result_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [SampleW-1:0]   cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam group_acc_t AccClear = '{
    minimum: {SampleW{1'b1}}, maximum: '0, total: '0, tally: '0
  };

  logic [SampleW-1:0] mean_gap_q;
  logic [SampleW-1:0] spread_cap_q;
  group_acc_t         major_acc;
  group_acc_t         minor_acc;
  logic               dropped_q;
  out_item_t          estimate_queue[$];

  function automatic group_acc_t absorb(group_acc_t acc, logic [SampleW-1:0] v);
    if (v < acc.minimum) begin
      acc.minimum = v;
    end
    if (v > acc.maximum) begin
      acc.maximum = v;
    end
    acc.total = acc.total + TotalW'(v);
    acc.tally = acc.tally + TallyW'(1);
    return acc;
  endfunction

  // Mean with the extremes taken out; only called with at least three samples.
  function automatic logic [SampleW-1:0] trim_mean(group_acc_t acc);
    logic [TotalW-1:0] core;
    core = acc.total - TotalW'(acc.minimum) - TotalW'(acc.maximum);
    return SampleW'(core / (acc.tally - TallyW'(2)));
  endfunction

  function automatic out_item_t settle_set(group_acc_t lg, group_acc_t sg, logic dropped,
                                           logic [SampleW-1:0] gap,
                                           logic [SampleW-1:0] cap);
    out_item_t          r;
    logic [SampleW-1:0] lm;
    logic [SampleW-1:0] sm;
    logic [SampleW-1:0] mean_delta;
    logic [SampleW-1:0] spread;
    r = '0;
    if (dropped) begin
      r.status = STATUS_OVERFLOW;
    end else if (lg.tally < MinTally) begin
      r.status = STATUS_LARGE_FEW;
    end else if (sg.tally != 0 && sg.tally < MinTally) begin
      r.status = STATUS_SMALL_FEW;
    end else begin
      r.status = STATUS_OK;
      lm = trim_mean(lg);
      spread = lg.maximum - lg.minimum;
      sm = (sg.tally != 0) ? trim_mean(sg) : '0;
      mean_delta = (lm > sm) ? lm - sm : sm - lm;
      if (sm == 0 || (mean_delta > gap && spread < cap)) begin
        r.voltage_estimate = lm;
      end else begin
        r.voltage_estimate = sm;
        r.used_small = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      mean_gap_q = MeanDiffReset;
      spread_cap_q = SpreadReset;
      major_acc = AccClear;
      minor_acc = AccClear;
      dropped_q = 1'b0;
      estimate_queue.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgMeanDiff: mean_gap_q = cfg_data_i;
          CfgSpread:   spread_cap_q = cfg_data_i;
          default: ;
        endcase
      end

      if (push_i && !full_i) begin
        // A sample for a group that is already full is dropped and remembered.
        if (item_i.group) begin
          if (minor_acc.tally >= MaxGroupSamples) dropped_q = 1'b1;
          else minor_acc = absorb(minor_acc, item_i.sample);
        end else begin
          if (major_acc.tally >= MaxGroupSamples) dropped_q = 1'b1;
          else major_acc = absorb(major_acc, item_i.sample);
        end
        if (item_i.end_of_set) begin
          estimate_queue.push_back(settle_set(major_acc, minor_acc, dropped_q,
                                              mean_gap_q, spread_cap_q));
          major_acc = AccClear;
          minor_acc = AccClear;
          dropped_q = 1'b0;
        end
      end

      if (pop_i && !empty_i) begin
        if (estimate_queue.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%0t: result with no set pending: est=%0d used_small=%0b status=%0d",
                     $realtime, result_i.voltage_estimate, result_i.used_small,
                     result_i.status);
          end
          fail_count_o++;
        end else begin
          want = estimate_queue.pop_front();
          if (result_i.voltage_estimate !== want.voltage_estimate ||
              result_i.used_small !== want.used_small ||
              result_i.status !== want.status) begin
            if (fail_count_o < 10) begin
              $display("%0t: mismatch: expected est=%0d used_small=%0b status=%0d, %s",
                       $realtime, want.voltage_estimate, want.used_small, want.status,
                       $sformatf("got est=%0d used_small=%0b status=%0d",
                                 result_i.voltage_estimate, result_i.used_small,
                                 result_i.status));
            end
            fail_count_o++;
          end
        end
      end
      pending_o = estimate_queue.size();
    end
  end

endmodule

>>> dv/dual_trimmed_mean_ocv_select_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_trimmed_mean_ocv_select_unit_test: stimulus and verdict for the selector
// Sends a few hand-built sample sets, then random sets over several limit
// settings and idling patterns, while a checker predicts every result.
// ----------------------------------------------------------------------------
module dual_trimmed_mean_ocv_select_unit_test;
  import dtm_pkg::*;

  localparam int SettleCycles = 2 * TotalW + 30;
  localparam int WatchdogLimit = 4000;
  localparam int ItemsPerPhase = 250;
  localparam int PhaseCount = 8;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  in_item_t             push_item;
  logic                 pop;
  logic                 empty;
  out_item_t            result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index;
  logic [SampleW-1:0]   cfg_data;
  int                   fail_count;
  int                   pending;
  int                   idle_pct;
  int                   stall_pct;
  int                   sent_in_phase;
  int                   quiet_cycles;

  always #10 clk_i = ~clk_i;

  dual_trimmed_mean_ocv_select_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (push_item),
    .pop        (pop),
    .empty      (empty),
    .result_o   (result),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  ocv_select_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_i      (full),
    .item_i      (push_item),
    .pop_i       (pop),
    .empty_i     (empty),
    .result_i    (result),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(negedge clk_i) begin
    pop <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Ends the run when no transaction of any kind completes for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic in_item_t make_item(logic [SampleW-1:0] s, logic g, logic e);
    in_item_t it;
    it.sample = s;
    it.group = g;
    it.end_of_set = e;
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with push still high.
  task automatic drive_sample(input in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    push_item <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    sent_in_phase++;
  endtask

  task automatic load_limits(input logic [SampleW-1:0] gap, input logic [SampleW-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_index <= CfgMeanDiff;
    cfg_data <= gap;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_index <= CfgSpread;
    cfg_data <= cap;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic int pick_span();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 8;
      2:       return 128;
      3:       return 1024;
      default: return 65535;
    endcase
  endfunction

  // One set with random group sizes; most are well formed, some too short or
  // too long. Minor samples sit near the major level so that the mean
  // comparison lands on both sides of the threshold.
  task automatic send_random_set();
    int                 major_n;
    int                 minor_n;
    int                 pick;
    int                 major_span;
    int                 minor_span;
    int                 window;
    int                 r;
    logic [SampleW-1:0] major_mid;
    logic [SampleW-1:0] minor_mid;
    in_item_t           it;
    pick = $urandom_range(0, 99);
    if (pick < 86) major_n = $urandom_range(3, MaxGroupSamples);
    else if (pick < 94) major_n = $urandom_range(0, 2);
    else major_n = $urandom_range(MaxGroupSamples + 1, MaxGroupSamples + 4);
    pick = $urandom_range(0, 99);
    if (pick < 30) minor_n = 0;
    else if (pick < 88) minor_n = $urandom_range(3, MaxGroupSamples);
    else if (pick < 95) minor_n = $urandom_range(1, 2);
    else minor_n = $urandom_range(MaxGroupSamples + 1, MaxGroupSamples + 3);
    if (major_n + minor_n == 0) minor_n = 1;

    major_mid = SampleW'($urandom);
    major_span = pick_span();
    case ($urandom_range(0, 3))
      0:       window = 16;
      1:       window = 64;
      2:       window = 600;
      default: window = 32768;
    endcase
    minor_mid = major_mid + SampleW'($urandom_range(0, 2 * window)) - SampleW'(window);
    minor_span = pick_span();
    if ($urandom_range(0, 9) == 0) begin
      minor_mid = '0;
      minor_span = 0;
    end

    // Each step picks the group of the next sample in proportion to what is left.
    while (major_n + minor_n > 0) begin
      r = $urandom_range(1, major_n + minor_n);
      it.group = (r > major_n) ? 1'b1 : 1'b0;
      if (it.group) begin
        it.sample = minor_mid + SampleW'($urandom_range(0, minor_span))
                    - SampleW'(minor_span / 2);
        minor_n--;
      end else begin
        it.sample = major_mid + SampleW'($urandom_range(0, major_span))
                    - SampleW'(major_span / 2);
        major_n--;
      end
      it.end_of_set = (major_n + minor_n == 0);
      drive_sample(it);
    end
  endtask

  initial begin
    int ph;
    int j;
    rst_ni = 1'b0;
    push = 1'b0;
    push_item = '0;
    cfg_valid = 1'b0;
    cfg_index = CfgMeanDiff;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    sent_in_phase = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Full-scale samples with only the major group present.
    drive_sample(make_item(16'h0000, 1'b0, 1'b0));
    drive_sample(make_item(16'hFFFF, 1'b0, 1'b0));
    drive_sample(make_item(16'h8000, 1'b0, 1'b1));
    // A set holding a single minor sample has too few major samples.
    drive_sample(make_item(16'h1234, 1'b1, 1'b1));
    // Enough major samples, but only two minor ones.
    drive_sample(make_item(16'd100, 1'b0, 1'b0));
    drive_sample(make_item(16'd200, 1'b0, 1'b0));
    drive_sample(make_item(16'd300, 1'b0, 1'b0));
    drive_sample(make_item(16'hAAAA, 1'b1, 1'b0));
    drive_sample(make_item(16'h0007, 1'b1, 1'b1));
    // One sample more than a group can hold.
    for (j = 0; j <= MaxGroupSamples; j++) begin
      drive_sample(make_item(SampleW'(j * 4099), 1'b0, j == MaxGroupSamples));
    end
    push <= 1'b0;
    drain();

    for (ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0:       load_limits('0, '0);
        1:       load_limits('1, '1);
        2:       load_limits('0, '1);
        3:       load_limits('1, '0);
        4:       load_limits(MeanDiffReset, SpreadReset);
        default: load_limits(SampleW'($urandom_range(0, 300)),
                             SampleW'($urandom_range(0, 2048)));
      endcase
      case (ph % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 48;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 48;
        end
        default: begin
          idle_pct = 6;
          stall_pct = 6;
        end
      endcase
      sent_in_phase = 0;
      while (sent_in_phase < ItemsPerPhase) send_random_set();
      push <= 1'b0;
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
design/dtm_pkg.sv
design/dtm_front.sv
design/dtm_job_fifo.sv
design/dtm_back.sv
design/dual_trimmed_mean_ocv_select_unit.sv
design/dtm_checker.sv
dv/ocv_select_checker.sv
dv/dual_trimmed_mean_ocv_select_unit_test.sv
